FILE: rtl/dwpi_pkg.sv
// shared constants for the dual wheel pi speed control block
package dwpi_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 11;
  localparam int INTEG_W    = 32;
  localparam int FIELD_W    = 16;

  localparam logic [1:0] MODE_EDGE_L = 2'd0;
  localparam logic [1:0] MODE_EDGE_R = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDUP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd5;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = -11'sd17;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = -11'sd4;
  localparam logic [FIELD_W-1:0]       WINDUP_RST     = 16'd200;
  localparam logic [FIELD_W-1:0]       DRIVE_MIN_RST  = 16'd50;
  localparam logic [FIELD_W-1:0]       DRIVE_MAX_RST  = 16'd400;

endpackage

FILE: rtl/dual_wheel_pi_speed_control_top.sv
// dual wheel pi speed loop: pulse counters, integrators, gain products and drive clamp
// a result appears on the output register after its tick beat is accepted
// throughput: one beat per cycle unless the output stalls; the chain is input
// register, error and integrator update, gain products, sum and clamp into the output register
// a stalled output holds every stage; rst_n is synchronous, active low, and clears the
// counters and integrators and loads the register reset values
module dual_wheel_pi_speed_control_top #(
  parameter int PULSE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dwpi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwpi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [dwpi_pkg::FIELD_W-1:0]        in_target_left,
  input  logic [dwpi_pkg::FIELD_W-1:0]        in_target_right,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dwpi_pkg::FIELD_W-1:0]        out_drive_left,
  output logic [dwpi_pkg::FIELD_W-1:0]        out_drive_right,
  output logic [dwpi_pkg::FIELD_W-1:0]        out_pulses_left,
  output logic [dwpi_pkg::FIELD_W-1:0]        out_pulses_right
);

  localparam int FW  = dwpi_pkg::FIELD_W;
  localparam int GW  = dwpi_pkg::GAIN_W;
  localparam int IW  = dwpi_pkg::INTEG_W;
  localparam int EW  = ((PULSE_WIDTH > FW) ? PULSE_WIDTH : FW) + 1;
  localparam int PPW = GW + EW;
  localparam int PIW = GW + IW;
  localparam int DW  = ((PPW > PIW) ? PPW : PIW) + 1;

  // configuration
  logic                 enable_r;
  logic signed [GW-1:0] prop_gain_r;
  logic signed [GW-1:0] integ_gain_r;
  logic [FW-1:0]        windup_r;
  logic [FW-1:0]        drive_min_r;
  logic [FW-1:0]        drive_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      prop_gain_r  <= dwpi_pkg::PROP_GAIN_RST;
      integ_gain_r <= dwpi_pkg::INTEG_GAIN_RST;
      windup_r     <= dwpi_pkg::WINDUP_RST;
      drive_min_r  <= dwpi_pkg::DRIVE_MIN_RST;
      drive_max_r  <= dwpi_pkg::DRIVE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dwpi_pkg::CFG_ENABLE:     enable_r     <= cfg_data[0];
        dwpi_pkg::CFG_PROP_GAIN:  prop_gain_r  <= $signed(cfg_data[GW-1:0]);
        dwpi_pkg::CFG_INTEG_GAIN: integ_gain_r <= $signed(cfg_data[GW-1:0]);
        dwpi_pkg::CFG_WINDUP:     windup_r     <= cfg_data;
        dwpi_pkg::CFG_DRIVE_MIN:  drive_min_r  <= cfg_data;
        dwpi_pkg::CFG_DRIVE_MAX:  drive_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic stall;
  logic advance;
  logic out_valid_r;

  assign stall    = out_valid_r && !out_ready;
  assign advance  = !stall;
  assign in_ready = advance;

  // input register
  logic          s0_valid_r;
  logic [1:0]    s0_mode_r;
  logic [FW-1:0] s0_tl_r;
  logic [FW-1:0] s0_tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (advance) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_mode_r <= in_mode;
      s0_tl_r   <= in_target_left;
      s0_tr_r   <= in_target_right;
    end
  end

  // counters and integrators
  logic [PULSE_WIDTH-1:0] cnt_l_r, cnt_l_nxt;
  logic [PULSE_WIDTH-1:0] cnt_r_r, cnt_r_nxt;
  logic signed [IW-1:0]   integ_l_r, integ_l_nxt;
  logic signed [IW-1:0]   integ_r_r, integ_r_nxt;
  logic                   s0_fire;
  logic                   tick_go;
  logic signed [EW-1:0]   err_l, err_r;

  function automatic logic integ_ok(input logic signed [EW-1:0] err,
                                    input logic signed [IW-1:0] acc,
                                    input logic [FW-1:0] limit);
    logic signed [IW:0] acc_x;
    logic signed [IW:0] mag;
    acc_x = (IW+1)'(acc);
    mag   = acc[IW-1] ? -acc_x : acc_x;
    integ_ok = (mag < $signed({{(IW+1-FW){1'b0}}, limit})) || (err == '0) ||
               (acc == '0) || (err[EW-1] != acc[IW-1]);
  endfunction

  assign s0_fire = s0_valid_r && advance;
  assign tick_go = s0_fire && (s0_mode_r == dwpi_pkg::MODE_TICK) && enable_r;
  assign err_l   = $signed({{(EW-FW){1'b0}}, s0_tl_r}) -
                   $signed({{(EW-PULSE_WIDTH){1'b0}}, cnt_l_r});
  assign err_r   = $signed({{(EW-FW){1'b0}}, s0_tr_r}) -
                   $signed({{(EW-PULSE_WIDTH){1'b0}}, cnt_r_r});

  always_comb begin
    cnt_l_nxt   = cnt_l_r;
    cnt_r_nxt   = cnt_r_r;
    integ_l_nxt = integ_l_r;
    integ_r_nxt = integ_r_r;
    if (s0_fire) begin
      case (s0_mode_r)
        dwpi_pkg::MODE_EDGE_L: cnt_l_nxt = cnt_l_r + 1'b1;
        dwpi_pkg::MODE_EDGE_R: cnt_r_nxt = cnt_r_r + 1'b1;
        dwpi_pkg::MODE_TICK: begin
          if (enable_r) begin
            cnt_l_nxt = '0;
            cnt_r_nxt = '0;
            if (integ_ok(err_l, integ_l_r, windup_r)) begin
              integ_l_nxt = integ_l_r + IW'(err_l);
            end
            if (integ_ok(err_r, integ_r_r, windup_r)) begin
              integ_r_nxt = integ_r_r + IW'(err_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_l_r   <= '0;
      cnt_r_r   <= '0;
      integ_l_r <= '0;
      integ_r_r <= '0;
    end else begin
      cnt_l_r   <= cnt_l_nxt;
      cnt_r_r   <= cnt_r_nxt;
      integ_l_r <= integ_l_nxt;
      integ_r_r <= integ_r_nxt;
    end
  end

  // stage 1: error and old integrator
  logic                 s1_valid_r;
  logic signed [EW-1:0] s1_err_l_r, s1_err_r_r;
  logic signed [IW-1:0] s1_acc_l_r, s1_acc_r_r;
  logic [FW-1:0]        s1_pl_r, s1_pr_r;

  // stage 2: gain products
  logic                  s2_valid_r;
  logic signed [PPW-1:0] s2_pp_l_r, s2_pp_r_r;
  logic signed [PIW-1:0] s2_pi_l_r, s2_pi_r_r;
  logic [FW-1:0]         s2_pl_r, s2_pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= tick_go;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  function automatic logic [FW-1:0] clamp(input logic signed [DW-1:0] drive,
                                          input logic [FW-1:0] lo,
                                          input logic [FW-1:0] hi);
    logic signed [DW-1:0] lo_x;
    logic signed [DW-1:0] hi_x;
    lo_x = $signed({{(DW-FW){1'b0}}, lo});
    hi_x = $signed({{(DW-FW){1'b0}}, hi});
    if (drive < lo_x) begin
      clamp = lo;
    end else if (drive > hi_x) begin
      clamp = hi;
    end else begin
      clamp = drive[FW-1:0];
    end
  endfunction

  logic signed [DW-1:0] drive_l, drive_r;
  assign drive_l = DW'(s2_pp_l_r) + DW'(s2_pi_l_r);
  assign drive_r = DW'(s2_pp_r_r) + DW'(s2_pi_r_r);

  logic [FW-1:0] out_dl_r, out_dr_r, out_pl_r, out_pr_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err_l_r <= err_l;
      s1_err_r_r <= err_r;
      s1_acc_l_r <= integ_l_r;
      s1_acc_r_r <= integ_r_r;
      s1_pl_r    <= FW'(cnt_l_r);
      s1_pr_r    <= FW'(cnt_r_r);
      s2_pp_l_r  <= PPW'(prop_gain_r) * PPW'(s1_err_l_r);
      s2_pp_r_r  <= PPW'(prop_gain_r) * PPW'(s1_err_r_r);
      s2_pi_l_r  <= PIW'(integ_gain_r) * PIW'(s1_acc_l_r);
      s2_pi_r_r  <= PIW'(integ_gain_r) * PIW'(s1_acc_r_r);
      s2_pl_r    <= s1_pl_r;
      s2_pr_r    <= s1_pr_r;
      out_dl_r   <= clamp(drive_l, drive_min_r, drive_max_r);
      out_dr_r   <= clamp(drive_r, drive_min_r, drive_max_r);
      out_pl_r   <= s2_pl_r;
      out_pr_r   <= s2_pr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_left   = out_dl_r;
  assign out_drive_right  = out_dr_r;
  assign out_pulses_left  = out_pl_r;
  assign out_pulses_right = out_pr_r;

`ifndef SYNTHESIS
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> (cnt_l_r == '0) && (cnt_r_r == '0))
    else $error("counters not cleared by tick");

  a_edge_left: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && (s0_mode_r == dwpi_pkg::MODE_EDGE_L)) |=>
      (cnt_l_r == PULSE_WIDTH'($past(cnt_l_r) + 1'b1)))
    else $error("left edge not counted");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_go |=> $stable(integ_l_r) && $stable(integ_r_r))
    else $error("integrator moved without tick");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r))
    else $error("result without product stage");
`endif

endmodule
